// File: hw/rtl/sfrc_pkg.sv
// sfrc_pkg: shared constants for the square-free range counter
// no dependencies; used by the channel interfaces and the top level

package sfrc_pkg;

  // width of a range bound on the ports
  localparam int unsigned VALUE_BITS = 16;

  // width of the result count on the ports
  localparam int unsigned COUNT_BITS = 16;

  // saturation limit of the count
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // first divisor root of the trial division
  localparam int unsigned FIRST_ROOT = 2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// File: hw/rtl/sfrc_if.sv
// sfrc_in_if and sfrc_out_if: valid/ready channels of the square-free range counter
// depends on sfrc_pkg for the payload types

interface sfrc_in_if;
  logic              valid;
  logic              ready;
  sfrc_pkg::value_t  range_low;
  sfrc_pkg::value_t  range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface sfrc_out_if;
  logic              valid;
  logic              ready;
  sfrc_pkg::count_t  free_count;

  modport source (output valid, output free_count, input ready);
  modport sink   (input valid, input free_count, output ready);
endinterface

// File: hw/rtl/square_free_range_count.sv
// square_free_range_count: counts the square-free integers of a range by trial division
// depends on sfrc_pkg and the channel interfaces in sfrc_if.sv
//
//   channel   dir   payload                      transfer when
//   in_ch     in    range_low, range_high        in_ch.valid && in_ch.ready
//   out_ch    out   free_count                   out_ch.valid && out_ch.ready
//
// one range at a time; each number v tries divisors d = r*r, r = 2, 3, ... while d <= v,
// each trial a bit-serial restoring remainder over VW dividend bits (VW = min(VALUE_WIDTH, 16))
// a square-free number ends in a test whose divisor square passes it, any other number in a zero remainder
// after the last number the count passes through S_FINISH into the output register, the next range is taken in S_IDLE
// rst_n is synchronous and clears the sequencer and the output valid
// a new range is taken while a result still waits; a finished count stalls on a full output

module square_free_range_count #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  sfrc_in_if.sink             in_ch,
  sfrc_out_if.source          out_ch
);

  // effective value width after masking to the port width
  localparam int unsigned VW = (VALUE_WIDTH < sfrc_pkg::VALUE_BITS) ?
                               VALUE_WIDTH : sfrc_pkg::VALUE_BITS;
  localparam int unsigned CW = VW + 1;  // current value, holds one past the top
  localparam int unsigned DW = VW + 2;  // divisor square, may pass the top value
  localparam int unsigned BW = $clog2(VW);

  localparam logic [BW-1:0] LAST_BIT = BW'(VW - 1);
  localparam logic [VW-1:0] ROOT_INIT = VW'(sfrc_pkg::FIRST_ROOT);
  localparam logic [DW-1:0] SQ_INIT = DW'(sfrc_pkg::FIRST_ROOT * sfrc_pkg::FIRST_ROOT);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_TEST   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [VW-1:0]           hi_r, hi_nxt;
  logic [CW-1:0]           cur_r, cur_nxt;
  logic [VW-1:0]           root_r, root_nxt;
  logic [DW-1:0]           sq_r, sq_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [VW-1:0]           sh_r, sh_nxt;
  logic [BW-1:0]           bit_r, bit_nxt;
  sfrc_pkg::count_t        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sfrc_pkg::count_t        out_count_r, out_count_nxt;

  logic                    in_xfer;
  logic                    out_free;
  logic [DW:0]             rem_sh;
  logic [DW:0]             rem_sub;
  logic [DW-1:0]           rem_step;
  logic [DW-1:0]           cur_ext;
  sfrc_pkg::count_t        count_inc;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.free_count = out_count_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  // one restoring remainder step: bring in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem_r, sh_r[VW-1]};
  assign rem_sub  = rem_sh - {1'b0, sq_r};
  assign rem_step = (rem_sh >= {1'b0, sq_r}) ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

  assign cur_ext   = {1'b0, cur_r};
  assign count_inc = (count_r == sfrc_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    bit_nxt       = bit_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cur_nxt   = {1'b0, in_ch.range_low[VW-1:0]};
          hi_nxt    = in_ch.range_high[VW-1:0];
          count_nxt = '0;
          state_nxt = S_START;
        end
      end
      // next number, or the end of the range
      S_START: begin
        if (cur_r > {1'b0, hi_r}) begin
          state_nxt = S_FINISH;
        end else begin
          root_nxt  = ROOT_INIT;
          sq_nxt    = SQ_INIT;
          state_nxt = S_TEST;
        end
      end
      // divisor square past the number means no square divides it
      S_TEST: begin
        if (sq_r > cur_ext) begin
          count_nxt = count_inc;
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_START;
        end else begin
          rem_nxt   = '0;
          sh_nxt    = cur_r[VW-1:0];
          bit_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      // bit-serial remainder of the number by the divisor square
      S_DIV: begin
        rem_nxt = rem_step;
        sh_nxt  = {sh_r[VW-2:0], 1'b0};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == LAST_BIT) begin
          if (rem_step == '0) begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = S_START;
          end else begin
            sq_nxt    = sq_r + {1'b0, root_r, 1'b1};
            root_nxt  = root_r + 1'b1;
            state_nxt = S_TEST;
          end
        end
      end
      // hand the count to the output register once it is free
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    hi_r        <= hi_nxt;
    cur_r       <= cur_nxt;
    root_r      <= root_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    bit_r       <= bit_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  // a taken range always starts the number walk
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_START))
    else $error("range transfer did not start the walk");

  // a trial division only runs for a divisor square that does not exceed the number
  a_div_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (sq_r <= cur_ext))
    else $error("trial division with divisor square above the number");

  // the output valid rises only from the finishing step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result raised outside the finishing step");

  // a trial never starts with a divisor below the first square
  a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (sq_r >= SQ_INIT && root_r >= ROOT_INIT))
    else $error("divisor below the first square");

endmodule
